// File: hw/rtl/kts_pkg.sv
// Shared types and constants for the key table search unit.
// Depends on nothing; imported by kts_engine and key_table_search_unit.
`default_nettype none

package kts_pkg;

  // Fixed field widths of the item and result channels
  localparam int POS_W      = 11;
  localparam int KEY_W      = 32;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 48;  // index and key, padded to whole bytes
  localparam int OUT_DATA_W = 16;  // position, padded to whole bytes

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // Item kinds carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SEQ   = 2'd1,
    OP_BIN   = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] index;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/kts_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module kts_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/kts_engine.sv
// Search sequencer: owns the key memory, performs writes, linear scans and
// bisection probes. Depends on kts_pkg and kts_ram.
`default_nettype none

module kts_engine #(
  parameter int TableDepth = kts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      item_valid_i,
  output logic                           item_ready_o,
  input  wire kts_pkg::item_t            item_i,
  input  wire logic [kts_pkg::POS_W-1:0] len_i,
  output kts_pkg::res_t                  res_o,
  input  wire logic                      res_ready_i
);

  import kts_pkg::*;

  localparam int AW   = $clog2(TableDepth);
  localparam int LH_W = POS_W + 1;

  typedef enum logic [2:0] {
    IDLE,
    SEQ,
    BIN_ISSUE,
    BIN_CMP,
    RESULT
  } state_e;

  state_e            state_q, state_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [POS_W-1:0]  cnt_q, cnt_d;
  logic [POS_W-1:0]  chk_pos_q, chk_pos_d;
  logic              chk_vld_q, chk_vld_d;
  logic [LH_W-1:0]   low_q, low_d;
  logic [LH_W-1:0]   high_q, high_d;
  logic [POS_W-1:0]  mid_q, mid_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;

  logic [POS_W-1:0]  used_len;
  logic [LH_W:0]     mid_sum;
  logic [POS_W-1:0]  mid;
  logic              wr_ok;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  function automatic logic [AW-1:0] addr_of(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] pm1;
    pm1 = pos - POS_W'(1);
    return AW'(pm1);
  endfunction

  // Saturate the configured length at the table depth
  assign used_len = (32'(len_i) > 32'(TableDepth)) ? POS_W'(TableDepth) : len_i;
  assign mid_sum  = {1'b0, low_q} + {1'b0, high_q};
  assign mid      = POS_W'(mid_sum[LH_W:1]);
  assign wr_ok    = (item_i.index != '0) && (32'(item_i.index) <= 32'(TableDepth));

  assign ram_waddr = addr_of(item_i.index);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    chk_pos_d = chk_pos_q;
    chk_vld_d = chk_vld_q;
    low_d     = low_q;
    high_d    = high_q;
    mid_d     = mid_q;
    res_pos_d = res_pos_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = addr_of(cnt_q);

    unique case (state_q)
      IDLE: begin
        if (item_valid_i) begin
          key_d = item_i.key;
          unique case (op_e'(item_i.op))
            OP_WRITE: ram_we = wr_ok;
            OP_SEQ: begin
              cnt_d     = used_len;
              chk_vld_d = 1'b0;
              state_d   = SEQ;
            end
            OP_BIN: begin
              low_d   = LH_W'(1);
              high_d  = LH_W'(used_len);
              state_d = BIN_ISSUE;
            end
            default: ;
          endcase
        end
      end
      SEQ: begin
        // Compare the entry fetched last cycle while fetching the next one down
        if (chk_vld_q && (ram_rdata == key_q)) begin
          res_pos_d = chk_pos_q;
          state_d   = RESULT;
        end else if (cnt_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = addr_of(cnt_q);
          chk_pos_d = cnt_q;
          chk_vld_d = 1'b1;
          cnt_d     = cnt_q - POS_W'(1);
        end else begin
          res_pos_d = '0;
          state_d   = RESULT;
        end
      end
      BIN_ISSUE: begin
        if (low_q <= high_q) begin
          ram_re    = 1'b1;
          ram_raddr = addr_of(mid);
          mid_d     = mid;
          state_d   = BIN_CMP;
        end else begin
          res_pos_d = '0;
          state_d   = RESULT;
        end
      end
      BIN_CMP: begin
        if (ram_rdata == key_q) begin
          res_pos_d = mid_q;
          state_d   = RESULT;
        end else begin
          if ($signed(key_q) < $signed(ram_rdata)) begin
            high_d = LH_W'(mid_q) - LH_W'(1);
          end else begin
            low_d = LH_W'(mid_q) + LH_W'(1);
          end
          state_d = BIN_ISSUE;
        end
      end
      RESULT: begin
        if (res_ready_i) begin
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    cnt_q     <= cnt_d;
    chk_pos_q <= chk_pos_d;
    low_q     <= low_d;
    high_q    <= high_d;
    mid_q     <= mid_d;
    res_pos_q <= res_pos_d;
  end

  // Writes happen only while idle, so a read never meets a write in flight
  kts_ram #(
    .Width (KEY_W),
    .Depth (TableDepth)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_i.key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign item_ready_o   = (state_q == IDLE);
  assign res_o.valid    = (state_q == RESULT);
  assign res_o.position = res_pos_q;
  assign res_o.found    = (res_pos_q != '0);

  // The fetched position always sits one above the next one to fetch
  a_seq_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ && chk_vld_q) |-> (chk_pos_q == cnt_q + POS_W'(1)))
    else $error("scan position tracking lost");

  // A bisection probe never targets position zero
  a_mid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BIN_CMP) |-> (mid_q != '0))
    else $error("probe at position zero");

  // A compare either finishes or returns to issue another probe
  a_bin_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BIN_CMP) |=> (state_q == BIN_ISSUE || state_q == RESULT))
    else $error("bisection left its loop");

  // The memory is written only while no search is running
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == IDLE && !ram_re))
    else $error("write during search");

endmodule

`default_nettype wire

// File: hw/rtl/key_table_search_unit.sv
// Top level of the key table search unit: stream channels, length register
// and result register around the search sequencer. Depends on kts_pkg,
// kts_engine and kts_ram.
//
// Use:
//  - The length register (positions 1 to table_length in use) is written on
//    the cfg channel, which is always ready. Write it only while the unit is
//    idle. Reset clears it to zero.
//  - Each input item carries its kind in s_axis_tuser: write entry,
//    linear search or bisection search; unused kinds are dropped.
//  - A write yields no result item. A write whose index
//    is zero or beyond the table depth is dropped.
//  - A linear search fetches one entry per cycle from the top position
//    downward. The single read port of the key memory sets this rate.
//  - A bisection search runs each probe as a memory read, then a compare.
//  - One item is processed at a time: s_axis_tready is high only while the
//    sequencer is idle. The output register lets the next item be taken while
//    a result still waits for the receiver.
//  - When the receiver stalls, the result holds in the output register; a
//    second finished search holds in the sequencer until the register frees.
//  - Reset empties the output register and returns the sequencer to idle.
//    The key memory is not cleared: read only entries that were written.
`default_nettype none

module key_table_search_unit #(
  parameter int TableDepth = kts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Length register write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [kts_pkg::POS_W-1:0]      cfg_data_i,
  // Input items
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [kts_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // entry_index, entry_key, zero pad
  input  wire logic [kts_pkg::OP_W-1:0]       s_axis_tuser,  // op
  // Result items
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [kts_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // position, zero pad
  output logic                                m_axis_tuser   // found
);

  import kts_pkg::*;

  logic [POS_W-1:0] len_q;
  item_t            item;
  res_t             res;
  logic             out_free;
  logic             m_valid_q;
  logic [POS_W-1:0] m_pos_q;
  logic             m_found_q;

  // Length register: always ready, keep the low 11 bits
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  // Unpack the input item
  assign item.op    = s_axis_tuser;
  assign item.index = s_axis_tdata[POS_W-1:0];
  assign item.key   = s_axis_tdata[POS_W+KEY_W-1:POS_W];

  kts_engine #(
    .TableDepth (TableDepth)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .len_i        (len_q),
    .res_o        (res),
    .res_ready_i  (out_free)
  );

  // Output register: load when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      m_pos_q   <= res.position;
      m_found_q <= res.found;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_pos_q);
  assign m_axis_tuser  = m_found_q;

endmodule

`default_nettype wire
